@@ hdl/mep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_pkg
// shared types and constants for the escape-time pixel evaluator
// ----------------------------------------------------------------------------
package mep_pkg;

  localparam int FRAC          = 28;
  localparam int ZW            = 48;
  localparam int DIM_W         = 13;
  localparam int POS_W         = 12;
  localparam int SPAN_W        = 33;
  localparam int NUM_W         = 45;
  localparam int LIMIT_W       = 16;
  localparam int IDX_W         = 24;
  localparam int MUL_W         = 31;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int DIV_STEPS_W   = 6;
  localparam int COLOR_STEPS_W = 4;

  localparam logic [DIM_W-1:0] MAX_DIMENSION = DIM_W'(4096);
  localparam logic signed [ZW-1:0] TWO  = ZW'(2) << FRAC;
  localparam logic signed [ZW-1:0] FOUR = ZW'(4) << FRAC;

  localparam logic [DIV_STEPS_W-1:0] MAP_LAST = DIV_STEPS_W'(NUM_W - 1);

  localparam logic [16:0] K_BLUE  = 17'd4335;
  localparam logic [16:0] K_GREEN = 17'd3825;
  localparam logic [16:0] K_RED   = 17'd2295;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_LOW   = 3'd0,
    REG_REAL_HIGH  = 3'd1,
    REG_IMAG_LOW   = 3'd2,
    REG_IMAG_HIGH  = 3'd3,
    REG_WIDTH      = 3'd4,
    REG_HEIGHT     = 3'd5,
    REG_ITER_LIMIT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] pixel_col;
    logic [POS_W-1:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_index;
    logic [7:0]         first_byte;
    logic [7:0]         second_byte;
    logic [7:0]         third_byte;
    logic [LIMIT_W-1:0] iterations_done;
    logic               inside_set;
  } result_t;

  typedef struct packed {
    logic signed [31:0] real_low;
    logic signed [31:0] real_high;
    logic signed [31:0] imag_low;
    logic signed [31:0] imag_high;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
  } window_t;

  typedef struct packed {
    logic signed [ZW-1:0] cr;
    logic signed [ZW-1:0] ci;
    logic [IDX_W-1:0]     pixel_index;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHECK,
    B_UPDATE,
    B_DIV,
    B_COLOR,
    B_OUT
  } back_state_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > MAX_DIMENSION) r = MAX_DIMENSION;
    return r;
  endfunction

endpackage

@@ hdl/mep_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_front
// maps a pixel position into the complex window with two serial dividers
// ----------------------------------------------------------------------------
module mep_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mep_pkg::pixel_t pixel,
  input  mep_pkg::window_t win,
  input  logic            queue_full,
  output logic            busy,
  output logic            push,
  output mep_pkg::job_t   job
);
  import mep_pkg::*;

  front_state_t state, state_next;

  logic [NUM_W-1:0]       num_re, num_im;
  logic [DIM_W:0]         rem_re, rem_im;
  logic [DIM_W-1:0]       dim_re, dim_im;
  logic                   neg_re, neg_im;
  logic signed [31:0]     lo_re, lo_im;
  logic [IDX_W-1:0]       index;
  logic [DIV_STEPS_W-1:0] step;

  logic signed [SPAN_W-1:0]  span_re, span_im;
  logic signed [SPAN_W+12:0] prod_re, prod_im;
  logic [SPAN_W+12:0]        abs_re, abs_im;
  logic [DIM_W-1:0]          w_eff, h_eff;
  logic [DIM_W+POS_W-1:0]    idx_full;
  logic [DIM_W:0]            sh_re, sh_im;
  logic                      ge_re, ge_im;
  logic                      accept;
  logic signed [ZW-1:0]      q_re, q_im;

  assign accept = start && !busy;

  always_comb begin
    w_eff    = eff_dim(win.image_width);
    h_eff    = eff_dim(win.image_height);
    span_re  = SPAN_W'(win.real_high) - SPAN_W'(win.real_low);
    span_im  = SPAN_W'(win.imag_high) - SPAN_W'(win.imag_low);
    prod_re  = $signed({1'b0, pixel.pixel_col}) * span_re;
    prod_im  = $signed({1'b0, pixel.pixel_row}) * span_im;
    abs_re   = prod_re[SPAN_W+12] ? 46'(-prod_re) : 46'(prod_re);
    abs_im   = prod_im[SPAN_W+12] ? 46'(-prod_im) : 46'(prod_im);
    idx_full = pixel.pixel_row * w_eff + (DIM_W+POS_W)'(pixel.pixel_col);
    // restoring step, quotient bits shift into the numerator register
    sh_re    = {rem_re[DIM_W-1:0], num_re[NUM_W-1]};
    sh_im    = {rem_im[DIM_W-1:0], num_im[NUM_W-1]};
    ge_re    = sh_re >= {1'b0, dim_re};
    ge_im    = sh_im >= {1'b0, dim_im};
    q_re     = neg_re ? -$signed(ZW'(num_re)) : $signed(ZW'(num_re));
    q_im     = neg_im ? -$signed(ZW'(num_im)) : $signed(ZW'(num_im));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (accept) state_next = F_DIV;
      F_DIV:  if (step == MAP_LAST) state_next = F_PUSH;
      F_PUSH: state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    push = 1'b0;
    unique case (state)
      F_IDLE: busy = queue_full;
      F_DIV:  busy = 1'b1;
      F_PUSH: push = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      num_re <= abs_re[NUM_W-1:0];
      num_im <= abs_im[NUM_W-1:0];
      neg_re <= prod_re[SPAN_W+12];
      neg_im <= prod_im[SPAN_W+12];
      rem_re <= '0;
      rem_im <= '0;
      dim_re <= w_eff;
      dim_im <= h_eff;
      lo_re  <= win.real_low;
      lo_im  <= win.imag_low;
      index  <= idx_full[IDX_W-1:0];
      step   <= '0;
    end else if (state == F_DIV) begin
      rem_re <= ge_re ? sh_re - {1'b0, dim_re} : sh_re;
      rem_im <= ge_im ? sh_im - {1'b0, dim_im} : sh_im;
      num_re <= {num_re[NUM_W-2:0], ge_re};
      num_im <= {num_im[NUM_W-2:0], ge_im};
      step   <= step + DIV_STEPS_W'(1);
    end
  end

  always_comb begin
    job.cr          = ZW'(lo_re) + q_re;
    job.ci          = ZW'(lo_im) + q_im;
    job.pixel_index = index;
  end

endmodule

@@ hdl/mep_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_queue
// two-entry queue of mapped jobs between front and back
// ----------------------------------------------------------------------------
module mep_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mep_pkg::job_t wr_job,
  input  logic          pop,
  output mep_pkg::job_t rd_job,
  output logic          empty,
  output logic          full
);
  import mep_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty  = (count == '0);
  assign full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_job;
  end

endmodule

@@ hdl/mep_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_back
// escape iteration, serial t divider and shared-multiplier color curves
// ----------------------------------------------------------------------------
module mep_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        empty,
  input  mep_pkg::job_t               job,
  input  logic [mep_pkg::LIMIT_W-1:0] limit,
  output logic                        pop,
  output logic                        done,
  output mep_pkg::result_t            result
);
  import mep_pkg::*;

  back_state_t state, state_next;

  logic signed [ZW-1:0]      x, y, cr, ci;
  logic [IDX_W-1:0]          index;
  logic [LIMIT_W-1:0]        iter, tq;
  logic [LIMIT_W:0]          rem;
  logic signed [2*MUL_W-1:0] pxx, pyy, pxy;
  logic                      in_set;
  logic [COLOR_STEPS_W-1:0]  step;
  logic [16:0]               m_uu, m_tt, m_a, m_g, m_r;

  logic                      at_limit, out_bounds, escape_sq;
  logic signed [ZW-1:0]      xx, yy, xy2;
  logic signed [MUL_W-1:0]   xs, ys;
  logic [LIMIT_W:0]          rem_sh;
  logic                      rem_ge;
  logic [16:0]               t17, u17, opa, opb;
  logic [33:0]               prod;
  logic [16:0]               prod_sh;

  always_comb begin
    at_limit   = (iter == limit);
    out_bounds = (x > TWO) || (x < -TWO) || (y > TWO) || (y < -TWO);
    xs         = x[MUL_W-1:0];
    ys         = y[MUL_W-1:0];
    xx         = ZW'(pxx >>> FRAC);
    yy         = ZW'(pyy >>> FRAC);
    // 2xy then floor shift equals xy shifted one bit less
    xy2        = ZW'(pxy >>> (FRAC - 1));
    escape_sq  = (xx + yy) > FOUR;
    rem_sh     = {rem[LIMIT_W-1:0], 1'b0};
    rem_ge     = rem_sh >= {1'b0, limit};
    t17        = {1'b0, tq};
    u17        = 17'h10000 - t17;
  end

  // one product a step through a single multiplier
  always_comb begin
    opa = m_uu;
    opb = u17;
    case (step)
      4'd0: begin opa = u17;  opb = u17;     end
      4'd1: begin opa = t17;  opb = t17;     end
      4'd2: begin opa = m_uu; opb = u17;     end
      4'd3: begin opa = m_a;  opb = t17;     end
      4'd4: begin opa = m_uu; opb = m_tt;    end
      4'd5: begin opa = m_tt; opb = t17;     end
      4'd6: begin opa = m_r;  opb = u17;     end
      4'd7: begin opa = m_a;  opb = K_BLUE;  end
      4'd8: begin opa = m_g;  opb = K_GREEN; end
      4'd9: begin opa = m_r;  opb = K_RED;   end
      default: begin opa = m_uu; opb = u17;  end
    endcase
    prod    = opa * opb;
    prod_sh = prod[32:16];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (!empty) state_next = B_CHECK;
      B_CHECK: begin
        if (at_limit)        state_next = B_OUT;
        else if (out_bounds) state_next = B_DIV;
        else                 state_next = B_UPDATE;
      end
      B_UPDATE: state_next = escape_sq ? B_DIV : B_CHECK;
      B_DIV:    if (step == 4'd15) state_next = B_COLOR;
      B_COLOR:  if (step == 4'd9) state_next = B_OUT;
      B_OUT:    state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (state)
      B_IDLE:  pop = !empty;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == B_OUT);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        x      <= '0;
        y      <= '0;
        cr     <= job.cr;
        ci     <= job.ci;
        index  <= job.pixel_index;
        iter   <= '0;
        in_set <= 1'b0;
      end
      B_CHECK: begin
        pxx    <= xs * xs;
        pyy    <= ys * ys;
        pxy    <= xs * ys;
        in_set <= at_limit;
        rem    <= {1'b0, iter};
        step   <= '0;
        m_a    <= '0;
        m_g    <= '0;
        m_r    <= '0;
      end
      B_UPDATE: begin
        if (!escape_sq) begin
          x    <= xx - yy + cr;
          y    <= xy2 + ci;
          iter <= iter + LIMIT_W'(1);
        end
      end
      B_DIV: begin
        rem  <= rem_ge ? rem_sh - {1'b0, limit} : rem_sh;
        tq   <= {tq[LIMIT_W-2:0], rem_ge};
        step <= (step == 4'd15) ? '0 : step + 4'd1;
      end
      B_COLOR: begin
        step <= step + 4'd1;
        case (step)
          4'd0:                   m_uu <= prod_sh;
          4'd1:                   m_tt <= prod_sh;
          4'd2, 4'd3, 4'd7:       m_a  <= prod_sh;
          4'd4, 4'd8:             m_g  <= prod_sh;
          default:                m_r  <= prod_sh;
        endcase
      end
      B_OUT: begin
        result.pixel_index     <= index;
        result.first_byte      <= m_a[8:1];
        result.second_byte     <= m_g[7:0];
        result.third_byte      <= m_r[7:0];
        result.iterations_done <= iter;
        result.inside_set      <= in_set;
      end
      default: begin
        x <= x;
      end
    endcase
  end

endmodule

@@ hdl/mandelbrot_escape_pixel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// escape-time evaluation of one pixel with polynomial coloring
// ----------------------------------------------------------------------------
// port group    direction  handshake
// pixel         in         start, accepted while busy is low
// result        out        done, one-cycle strobe
// cfg_*         in         cfg_write, no wait
//
// front: divide, then push; takes a new pixel only in idle with the queue not full
// back: pop, check and update per iteration, then limit check and output (inside set)
// or escape test in check or update, then divide, color and output (escaped)
// done is high in the cycle after the output cycle; the iteration loop sets the rate
// a two-entry queue decouples the halves; results cannot stall
// reset is synchronous and restores the default window
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  mep_pkg::pixel_t                pixel,
  output logic                           done,
  output mep_pkg::result_t               result,
  input  logic                           cfg_write,
  input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mep_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mep_pkg::*;

  window_t            win;
  logic [LIMIT_W-1:0] limit;
  logic               push, pop, empty, full;
  job_t               wr_job, rd_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.real_low     <= -32'sd536870912;
      win.real_high    <= 32'sd268435456;
      win.imag_low     <= -32'sd402653184;
      win.imag_high    <= 32'sd402653184;
      win.image_width  <= DIM_W'(1024);
      win.image_height <= DIM_W'(768);
      limit            <= LIMIT_W'(1000);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REAL_LOW:   win.real_low     <= cfg_data;
        REG_REAL_HIGH:  win.real_high    <= cfg_data;
        REG_IMAG_LOW:   win.imag_low     <= cfg_data;
        REG_IMAG_HIGH:  win.imag_high    <= cfg_data;
        REG_WIDTH:      win.image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:     win.image_height <= cfg_data[DIM_W-1:0];
        REG_ITER_LIMIT: limit            <= cfg_data[LIMIT_W-1:0];
        default:        limit            <= limit;
      endcase
    end
  end

  mep_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .pixel      (pixel),
    .win        (win),
    .queue_full (full),
    .busy       (busy),
    .push       (push),
    .job        (wr_job)
  );

  mep_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (empty),
    .full   (full)
  );

  mep_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .job    (rd_job),
    .limit  (limit),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

`ifndef SYNTHESIS
  // black points carry no color
  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    done && result.inside_set |->
      result.first_byte == 8'd0 && result.second_byte == 8'd0 &&
      result.third_byte == 8'd0)
    else $error("inside point with color");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("front idle after accept");
`endif

endmodule
